@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the subsampler RTL modules.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ rtl/core/y420s_pkg.sv @@
// Shared constants and types for the YUV444 to YUV420 subsampler.
// No dependencies; every RTL module of the block imports this package.
`default_nettype none

package y420s_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int DIM_W      = 13;
	localparam int POS_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int SLOT_W     = $clog2(LINE_DEPTH);
	localparam int SUM_W      = 9;
	localparam int ADDR_W     = 26;
	localparam int BYTE_W     = 8;
	localparam int PADDR_W    = 4;
	localparam int PDATA_W    = 32;

	typedef enum logic [1:0] {
		REG_CONVERT = 2'd0,
		REG_WIDTH   = 2'd1,
		REG_HEIGHT  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic             convert;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} cfg_t;

	typedef struct packed {
		logic                   three;
		logic [2:0][ADDR_W-1:0] addr;
		logic [2:0][BYTE_W-1:0] data;
	} seq_load_t;

endpackage

`default_nettype wire

@@ rtl/core/yuv444_to_yuv420_subsampler.sv @@
// An accepted item is registered in the compute stage, then in the result
// sequencer, before its first result appears. The single byte result port
// holds on res_stall and is occupied longer by a pixel that gives three results.
// Reset sets the configuration registers to their defaults and clears the
// frame position and both address counters; the chroma line buffer keeps its
// contents and is rewritten before it is read.
`default_nettype none

module yuv444_to_yuv420_subsampler import y420s_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               pix_valid,
	output logic               pix_stall,
	input  logic [BYTE_W-1:0]  luma_in,
	input  logic [BYTE_W-1:0]  cb_in,
	input  logic [BYTE_W-1:0]  cr_in,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [ADDR_W-1:0]  out_addr,
	output logic [BYTE_W-1:0]  out_byte,
	output logic               last_of_item
);

	cfg_t      cfg;
	logic      restart;
	logic      load_valid;
	seq_load_t load;
	logic      seq_free;

	y420s_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.restart (restart)
	);

	y420s_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.restart    (restart),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.luma_in    (luma_in),
		.cb_in      (cb_in),
		.cr_in      (cr_in),
		.load_valid (load_valid),
		.load       (load),
		.seq_free   (seq_free)
	);

	y420s_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_valid   (load_valid),
		.load         (load),
		.seq_free     (seq_free),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.out_addr     (out_addr),
		.out_byte     (out_byte),
		.last_of_item (last_of_item)
	);

endmodule

`default_nettype wire

@@ rtl/core/y420s_cfg.sv @@
// Configuration register file with an APB-style slave port.
// Depends on y420s_pkg for the register map and the configuration struct.
`default_nettype none

module y420s_cfg import y420s_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg,
	output logic               restart
);

	logic             convert_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic             wr;
	reg_idx_t         idx;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr     = psel & penable & pwrite;

	always_comb begin
		restart = 1'b0;
		prdata  = '0;
		case (idx)
			REG_CONVERT: begin
				restart = wr;
				prdata  = PDATA_W'(convert_q);
			end
			REG_WIDTH: begin
				restart = wr;
				prdata  = PDATA_W'(width_q);
			end
			REG_HEIGHT: begin
				restart = wr;
				prdata  = PDATA_W'(height_q);
			end
			default: begin
				restart = 1'b0;
				prdata  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			convert_q <= 1'b0;
			width_q   <= DIM_W'(1);
			height_q  <= DIM_W'(1);
		end else if (wr) begin
			case (idx)
				REG_CONVERT: convert_q <= pwdata[0];
				REG_WIDTH:   width_q   <= pwdata[DIM_W-1:0];
				REG_HEIGHT:  height_q  <= pwdata[DIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// A zero dimension acts as one; anything above the maximum acts as the maximum.
	always_comb begin
		cfg.convert = convert_q;
		if (width_q == '0) begin
			cfg.width = DIM_W'(1);
		end else if (width_q > DIM_W'(MAX_WIDTH)) begin
			cfg.width = DIM_W'(MAX_WIDTH);
		end else begin
			cfg.width = width_q;
		end
		if (height_q == '0) begin
			cfg.height = DIM_W'(1);
		end else if (height_q > DIM_W'(MAX_HEIGHT)) begin
			cfg.height = DIM_W'(MAX_HEIGHT);
		end else begin
			cfg.height = height_q;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/y420s_front.sv @@
// Frame position tracking, chroma line buffer and the single compute stage.
// Depends on y420s_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module y420s_front import y420s_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              restart,
	input  logic              pix_valid,
	output logic              pix_stall,
	input  logic [BYTE_W-1:0] luma_in,
	input  logic [BYTE_W-1:0] cb_in,
	input  logic [BYTE_W-1:0] cr_in,
	output logic              load_valid,
	output seq_load_t         load,
	input  logic              seq_free
);

	logic [POS_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [SUM_W-1:0]   hold_u_q;
	logic [SUM_W-1:0]   hold_v_q;
	logic [ADDR_W-1:0]  luma_q;
	logic [ADDR_W-1:0]  chroma_q;
	logic [ADDR_W-1:0]  area_q;
	logic [2*SUM_W-1:0] line_mem [LINE_DEPTH];

	logic               accept;
	logic               adv;
	logic               col_odd;
	logic               row_odd;
	logic               last_col;
	logic               last_row;
	logic               chroma_col;
	logic               line_wr;
	logic               emit;
	logic               col_wrap;
	logic               row_wrap;
	logic [SUM_W-1:0]   su_a;
	logic [SUM_W-1:0]   sv_a;
	logic [SLOT_W-1:0]  slot;

	logic               valid_s1;
	logic [BYTE_W-1:0]  y_s1;
	logic [BYTE_W-1:0]  u_s1;
	logic [BYTE_W-1:0]  v_s1;
	logic [SUM_W-1:0]   su_s1;
	logic [SUM_W-1:0]   sv_s1;
	logic               col_odd_s1;
	logic               row_odd_s1;
	logic               emit_s1;
	logic [ADDR_W-1:0]  pix_s1;
	logic [ADDR_W-1:0]  caddr_s1;
	logic [2*SUM_W-1:0] line_rd_s1;

	logic [SUM_W:0]     sum_u;
	logic [SUM_W:0]     sum_v;
	logic [1:0]         shift;
	logic [ADDR_W-1:0]  pair_addr;
	logic [ADDR_W-1:0]  base3;

	assign adv       = valid_s1 & seq_free;
	assign accept    = pix_valid & (~valid_s1 | adv);
	assign pix_stall = valid_s1 & ~adv;

	assign col_odd    = col_q[0];
	assign row_odd    = row_q[0];
	assign last_col   = DIM_W'(col_q) == (cfg.width - DIM_W'(1));
	assign last_row   = DIM_W'(row_q) == (cfg.height - DIM_W'(1));
	assign chroma_col = col_odd | last_col;
	assign line_wr    = chroma_col & ~row_odd & ~last_row;
	assign emit       = chroma_col & ~line_wr;
	assign col_wrap   = (DIM_W'(col_q) + DIM_W'(1)) >= cfg.width;
	assign row_wrap   = (DIM_W'(row_q) + DIM_W'(1)) >= cfg.height;
	assign slot       = SLOT_W'(col_q >> 1);
	assign su_a       = SUM_W'(cb_in) + (col_odd ? hold_u_q : '0);
	assign sv_a       = SUM_W'(cr_in) + (col_odd ? hold_v_q : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			hold_u_q <= '0;
			hold_v_q <= '0;
			luma_q   <= '0;
			chroma_q <= '0;
		end else if (restart) begin
			col_q    <= '0;
			row_q    <= '0;
			hold_u_q <= '0;
			hold_v_q <= '0;
			luma_q   <= '0;
			chroma_q <= '0;
		end else if (accept) begin
			if (!chroma_col) begin
				hold_u_q <= SUM_W'(cb_in);
				hold_v_q <= SUM_W'(cr_in);
			end
			if (col_wrap) begin
				col_q <= '0;
				if (row_wrap) begin
					row_q    <= '0;
					luma_q   <= '0;
					chroma_q <= '0;
				end else begin
					row_q    <= row_q + ROW_W'(1);
					luma_q   <= luma_q + ADDR_W'(1);
					chroma_q <= emit ? chroma_q + ADDR_W'(2) : chroma_q;
				end
			end else begin
				col_q    <= col_q + POS_W'(1);
				luma_q   <= luma_q + ADDR_W'(1);
				chroma_q <= emit ? chroma_q + ADDR_W'(2) : chroma_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		area_q <= ADDR_W'(cfg.width) * ADDR_W'(cfg.height);
	end

	always_ff @(posedge clk) begin
		if (accept && line_wr) begin
			line_mem[slot] <= {sv_a, su_a};
		end
		if (accept) begin
			line_rd_s1 <= line_mem[slot];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			y_s1       <= luma_in;
			u_s1       <= cb_in;
			v_s1       <= cr_in;
			su_s1      <= su_a;
			sv_s1      <= sv_a;
			col_odd_s1 <= col_odd;
			row_odd_s1 <= row_odd;
			emit_s1    <= emit;
			pix_s1     <= luma_q;
			caddr_s1   <= chroma_q;
		end
	end

	// The divisor is one, two or four pixels, so the average is a right shift.
	assign sum_u = (SUM_W + 1)'(su_s1)
		+ (row_odd_s1 ? (SUM_W + 1)'(line_rd_s1[SUM_W-1:0]) : '0);
	assign sum_v = (SUM_W + 1)'(sv_s1)
		+ (row_odd_s1 ? (SUM_W + 1)'(line_rd_s1[2*SUM_W-1:SUM_W]) : '0);
	assign shift     = 2'(col_odd_s1) + 2'(row_odd_s1);
	assign pair_addr = area_q + caddr_s1;
	assign base3     = pix_s1 + {pix_s1[ADDR_W-2:0], 1'b0};

	assign load_valid = valid_s1;

	always_comb begin
		if (cfg.convert) begin
			load.three   = emit_s1;
			load.addr[0] = pix_s1;
			load.data[0] = y_s1;
			load.addr[1] = pair_addr;
			load.data[1] = BYTE_W'(sum_u >> shift);
			load.addr[2] = pair_addr + ADDR_W'(1);
			load.data[2] = BYTE_W'(sum_v >> shift);
		end else begin
			load.three   = 1'b1;
			load.addr[0] = base3;
			load.data[0] = y_s1;
			load.addr[1] = base3 + ADDR_W'(1);
			load.data[1] = u_s1;
			load.addr[2] = base3 + ADDR_W'(2);
			load.data[2] = v_s1;
		end
	end

	`ASSERT_NEVER(a_col_in_frame, DIM_W'(col_q) >= cfg.width, "column beyond frame width")
	`ASSERT_CLK(a_restart_home, restart |=> col_q == '0 && row_q == '0 && luma_q == '0,
		"frame position not cleared after a register write")

endmodule

`default_nettype wire

@@ rtl/core/y420s_seq.sv @@
// Result sequencer: holds the bytes of one item and sends them one per cycle while res_stall is low.
// Depends on y420s_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module y420s_seq import y420s_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load_valid,
	input  seq_load_t         load,
	output logic              seq_free,
	output logic              res_valid,
	input  logic              res_stall,
	output logic [ADDR_W-1:0] out_addr,
	output logic [BYTE_W-1:0] out_byte,
	output logic              last_of_item
);

	typedef enum logic [1:0] {
		BYTE_Y = 2'd0,
		BYTE_U = 2'd1,
		BYTE_V = 2'd2
	} byte_sel_t;

	logic      busy_q;
	logic      three_q;
	byte_sel_t idx_q;
	seq_load_t ld_q;
	logic      take;
	logic      done;

	assign res_valid    = busy_q;
	assign last_of_item = three_q ? (idx_q == BYTE_V) : (idx_q == BYTE_Y);
	assign done         = busy_q & ~res_stall & last_of_item;
	assign seq_free     = ~busy_q | done;
	assign take         = load_valid & seq_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			three_q <= 1'b0;
			idx_q   <= BYTE_Y;
		end else if (take) begin
			busy_q  <= 1'b1;
			three_q <= load.three;
			idx_q   <= BYTE_Y;
		end else if (busy_q && !res_stall) begin
			if (last_of_item) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= (idx_q == BYTE_Y) ? BYTE_U : BYTE_V;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ld_q <= load;
		end
	end

	always_comb begin
		case (idx_q)
			BYTE_Y: begin
				out_addr = ld_q.addr[0];
				out_byte = ld_q.data[0];
			end
			BYTE_U: begin
				out_addr = ld_q.addr[1];
				out_byte = ld_q.data[1];
			end
			BYTE_V: begin
				out_addr = ld_q.addr[2];
				out_byte = ld_q.data[2];
			end
			default: begin
				out_addr = ld_q.addr[0];
				out_byte = ld_q.data[0];
			end
		endcase
	end

	`ASSERT_CLK(a_hold_on_stall, busy_q && res_stall |=> busy_q && $stable(idx_q),
		"sequencer moved while the result was stalled")
	`ASSERT_CLK(a_single_byte, busy_q && !three_q |-> idx_q == BYTE_Y,
		"single result item advanced past its luma byte")

endmodule

`default_nettype wire
